@@ sv/dcbp_pkg.sv @@
// Shared types, codes and helper functions of the display command byte parser.
`timescale 1ns / 1ps

package dcbp_pkg;

    // Configuration register indexes and their widths.
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 8;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_MAX_TEXT_LENGTH     = 3'd0,
        CFG_DEFAULT_COLOUR_CODE = 3'd1,
        CFG_DEFAULT_FONT_WIDTH  = 3'd2,
        CFG_DEFAULT_FONT_HEIGHT = 3'd3,
        CFG_FILL_COLOUR_CODE    = 3'd4
    } dcbp_cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [4:0] RST_MAX_TEXT_LENGTH     = 5'd25;
    localparam logic [7:0] RST_DEFAULT_COLOUR_CODE = 8'h10;
    localparam logic [7:0] RST_DEFAULT_FONT_WIDTH  = 8'd4;
    localparam logic [7:0] RST_DEFAULT_FONT_HEIGHT = 8'd5;
    localparam logic [7:0] RST_FILL_COLOUR_CODE    = 8'h15;

    // Protocol bytes.
    localparam logic [7:0] BYTE_FRAME_START = 8'hF2;
    localparam logic [7:0] BYTE_FRAME_END   = 8'hF3;
    localparam logic [7:0] BYTE_COMMAND     = 8'hF4;
    localparam logic [7:0] LETTER_CLEAR     = 8'h4E; // 'N'
    localparam logic [7:0] LETTER_REFRESH   = 8'h5A; // 'Z'
    localparam logic [7:0] LETTER_TEXT      = 8'h54; // 'T'
    localparam logic [7:0] LETTER_FONT      = 8'h46; // 'F'
    localparam logic [7:0] LETTER_LINE      = 8'h4C; // 'L'
    localparam logic [7:0] LETTER_POSITION  = 8'h58; // 'X'
    localparam logic [7:0] LETTER_COLOUR    = 8'h43; // 'C'
    localparam logic [7:0] LETTER_CIRCLE    = 8'h52; // 'R'
    localparam logic [7:0] LETTER_BOX       = 8'h42; // 'B'
    localparam logic [7:0] LETTER_FILL      = 8'h53; // 'S'
    localparam logic [7:0] LETTER_PIXEL     = 8'h50; // 'P'
    localparam logic [7:0] CHAR_ZERO        = 8'h30; // '0'
    localparam logic [7:0] CHAR_O           = 8'h4F; // 'O'
    localparam logic [7:0] PIXEL_RED        = 8'd200;

    // Draw command codes.
    typedef enum logic [3:0] {
        DRAW_CLEAR     = 4'd0,
        DRAW_REFRESH   = 4'd1,
        DRAW_TEXT_CHAR = 4'd2,
        DRAW_LINE      = 4'd3,
        DRAW_CIRCLE    = 4'd4,
        DRAW_BOX       = 4'd5,
        DRAW_FILL      = 4'd6,
        DRAW_PIXEL     = 4'd7,
        DRAW_FRAME_END = 4'd8
    } dcbp_cmd_t;

    // Parser modes, one-hot.
    typedef enum logic [16:0] {
        M_START   = 17'h00001,
        M_CMD     = 17'h00002,
        M_INSTR   = 17'h00004,
        M_TEXT    = 17'h00008,
        M_FONT_W  = 17'h00010,
        M_FONT_H  = 17'h00020,
        M_LINE_X  = 17'h00040,
        M_LINE_Y  = 17'h00080,
        M_POS_X   = 17'h00100,
        M_POS_Y   = 17'h00200,
        M_COLOUR  = 17'h00400,
        M_CIRCLE  = 17'h00800,
        M_BOX_X   = 17'h01000,
        M_BOX_Y   = 17'h02000,
        M_FILL    = 17'h04000,
        M_PIXEL_X = 17'h08000,
        M_PIXEL_Y = 17'h10000
    } dcbp_mode_t;

    // Current configuration as seen by the parser.
    typedef struct packed {
        logic [4:0] max_text_length;
        logic [7:0] default_colour_code;
        logic [7:0] default_font_width;
        logic [7:0] default_font_height;
        logic [7:0] fill_colour_code;
    } dcbp_cfg_t;

    // One draw command result.
    typedef struct packed {
        logic [3:0]        command;
        logic signed [7:0] x_start;
        logic signed [7:0] y_start;
        logic signed [7:0] x_end;
        logic signed [7:0] y_end;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [4:0]        font_index;
        logic [7:0]        text_char;
        logic              text_last;
    } dcbp_result_t;

    // A 2-bit channel value scaled to 0, 85, 170 or 255.
    function automatic logic [7:0] channel_level(input logic [1:0] code);
        channel_level = {code, code, code, code};
    endfunction

    // Font selection from the width code and the height (signed compare).
    function automatic logic [4:0] pick_font(input logic [7:0] width_code,
                                             input logic [7:0] height);
        logic signed [7:0] h;
        logic              bold;
        logic              outl;
        logic [4:0]        font;
        h    = $signed(height);
        bold = width_code[7];
        outl = !width_code[7] && width_code[6];
        unique case (width_code[3:0])
            4'd5:    font = (h < 8) ? 5'd1 : 5'd2;
            4'd6:
            begin
                if (h < 10)
                    font = 5'd3;
                else if (h < 11)
                    font = 5'd4;
                else if (h < 13)
                    font = 5'd5;
                else
                    font = outl ? 5'd6 : (bold ? 5'd7 : 5'd8);
            end
            4'd7:
            begin
                if (h < 14)
                    font = outl ? 5'd9 : (bold ? 5'd10 : 5'd11);
                else
                    font = outl ? 5'd12 : (bold ? 5'd13 : 5'd14);
            end
            4'd8:    font = outl ? 5'd15 : (bold ? 5'd16 : 5'd17);
            4'd9:
            begin
                if (h < 17)
                    font = bold ? 5'd18 : 5'd19;
                else
                    font = bold ? 5'd20 : 5'd21;
            end
            4'd10:   font = 5'd22;
            4'd11:   font = 5'd23;
            4'd12:   font = 5'd24;
            default: font = 5'd0;
        endcase
        pick_font = font;
    endfunction

endpackage

@@ sv/display_command_byte_parser.sv @@
// Top level of the display command byte parser: configuration registers and stream ports.
// A result reaches the master side through the result register, or the skid stage
// while the output stalls. Bytes are taken one per cycle while the skid stage is
// empty, so they keep being taken while one result waits (two requests deep).
// Reset (rst_n, asynchronous, active low) restores the configuration registers to their
// defaults, the parser to waiting for frame start, and empties the output stages.
`timescale 1ns / 1ps

module display_command_byte_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    // Slave side: tdata = rx_byte[7:0].
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,
    // Master side: tdata = x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24],
    // red[39:32], green[47:40], blue[55:48], font_index[60:56], text_char[68:61],
    // zeros[71:69]; tuser = command[3:0]; tlast = text_last.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [71:0]                        m_tdata,
    output logic [3:0]                         m_tuser,
    output logic                               m_tlast,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [dcbp_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [dcbp_pkg::CfgDataWidth-1:0]  cfg_data
);
    import dcbp_pkg::*;

    dcbp_cfg_t    cfg_reg;
    logic         byte_accept;
    logic         res_valid;
    dcbp_result_t res;
    dcbp_result_t out_res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_text_length     <= RST_MAX_TEXT_LENGTH;
            cfg_reg.default_colour_code <= RST_DEFAULT_COLOUR_CODE;
            cfg_reg.default_font_width  <= RST_DEFAULT_FONT_WIDTH;
            cfg_reg.default_font_height <= RST_DEFAULT_FONT_HEIGHT;
            cfg_reg.fill_colour_code    <= RST_FILL_COLOUR_CODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_TEXT_LENGTH:     cfg_reg.max_text_length     <= cfg_data[4:0];
                CFG_DEFAULT_COLOUR_CODE: cfg_reg.default_colour_code <= cfg_data;
                CFG_DEFAULT_FONT_WIDTH:  cfg_reg.default_font_width  <= cfg_data;
                CFG_DEFAULT_FONT_HEIGHT: cfg_reg.default_font_height <= cfg_data;
                CFG_FILL_COLOUR_CODE:    cfg_reg.fill_colour_code    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign byte_accept = s_tvalid && s_tready;

    // Byte decode and drawing state.
    dcbp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_accept),
        .rx_byte    (s_tdata),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Result register and skid stage.
    dcbp_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    // Pack the result onto the master bus.
    assign m_tdata = {3'd0, out_res.text_char, out_res.font_index, out_res.blue,
                      out_res.green, out_res.red, out_res.y_end, out_res.x_end,
                      out_res.y_start, out_res.x_start};
    assign m_tuser = out_res.command;
    assign m_tlast = out_res.text_last;

endmodule

@@ sv/dcbp_parser.sv @@
// Parser state registers and the single-pass decode of one received byte.
`timescale 1ns / 1ps

module dcbp_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  logic [7:0]            rx_byte,
    input  dcbp_pkg::dcbp_cfg_t   cfg,
    output logic                  res_valid,
    output dcbp_pkg::dcbp_result_t res
);
    import dcbp_pkg::*;

    dcbp_mode_t mode_reg, mode_next;
    logic [4:0] text_count_reg, text_count_next;
    logic [7:0] font_width_reg, font_width_next;
    logic [7:0] font_height_reg, font_height_next;
    logic [7:0] start_x_reg, start_x_next;
    logic [7:0] start_y_reg, start_y_next;
    logic [7:0] end_x_reg, end_x_next;
    logic [7:0] end_y_reg, end_y_next;
    logic [7:0] colour_reg, colour_next;

    logic [7:0] text_c;
    logic [4:0] count_inc;
    logic       text_end;

    // Text character handling: zero becomes O in the 5x8 font.
    always_comb
    begin
        text_c = rx_byte;
        if (rx_byte == CHAR_ZERO && font_width_reg == 8'd5 && font_height_reg == 8'd8)
            text_c = CHAR_O;
        count_inc = text_count_reg + 5'd1;
        text_end  = (count_inc >= cfg.max_text_length) || (text_c == 8'd0);
    end

    // Next state and result for the byte.
    always_comb
    begin
        mode_next        = mode_reg;
        text_count_next  = text_count_reg;
        font_width_next  = font_width_reg;
        font_height_next = font_height_reg;
        start_x_next     = start_x_reg;
        start_y_next     = start_y_reg;
        end_x_next       = end_x_reg;
        end_y_next       = end_y_reg;
        colour_next      = colour_reg;
        res_valid        = 1'b0;
        res              = '0;

        unique case (mode_reg)
            M_START:
            begin
                if (rx_byte == BYTE_FRAME_START)
                begin
                    text_count_next  = 5'd0;
                    font_width_next  = cfg.default_font_width;
                    font_height_next = cfg.default_font_height;
                    start_x_next     = 8'd0;
                    start_y_next     = 8'd0;
                    end_x_next       = 8'd0;
                    end_y_next       = 8'd0;
                    colour_next      = cfg.default_colour_code;
                    mode_next        = M_CMD;
                end
            end
            M_CMD:
            begin
                if (rx_byte == BYTE_COMMAND)
                    mode_next = M_INSTR;
            end
            M_INSTR:
            begin
                mode_next = M_CMD;
                unique case (rx_byte)
                    BYTE_FRAME_END:
                    begin
                        mode_next   = M_START;
                        res.command = DRAW_FRAME_END;
                        res_valid   = 1'b1;
                    end
                    LETTER_CLEAR:
                    begin
                        res.command = DRAW_CLEAR;
                        res_valid   = 1'b1;
                    end
                    LETTER_REFRESH:
                    begin
                        res.command = DRAW_REFRESH;
                        res_valid   = 1'b1;
                    end
                    LETTER_TEXT:
                    begin
                        mode_next       = M_TEXT;
                        text_count_next = 5'd0;
                    end
                    LETTER_FONT:     mode_next = M_FONT_W;
                    LETTER_LINE:     mode_next = M_LINE_X;
                    LETTER_POSITION: mode_next = M_POS_X;
                    LETTER_COLOUR:   mode_next = M_COLOUR;
                    LETTER_CIRCLE:   mode_next = M_CIRCLE;
                    LETTER_BOX:      mode_next = M_BOX_X;
                    LETTER_FILL:     mode_next = M_FILL;
                    LETTER_PIXEL:    mode_next = M_PIXEL_X;
                    default:         mode_next = M_CMD;
                endcase
            end
            M_TEXT:
            begin
                text_count_next = count_inc;
                res.command     = DRAW_TEXT_CHAR;
                res.x_start     = start_x_reg;
                res.y_start     = start_y_reg;
                res.red         = channel_level(colour_reg[5:4]);
                res.green       = channel_level(colour_reg[3:2]);
                res.blue        = channel_level(colour_reg[1:0]);
                res.font_index  = pick_font(font_width_reg, font_height_reg);
                res.text_char   = text_c;
                res.text_last   = text_end;
                res_valid       = 1'b1;
                if (text_end)
                    mode_next = M_CMD;
            end
            M_FONT_W:
            begin
                font_width_next = rx_byte;
                mode_next       = M_FONT_H;
            end
            M_FONT_H:
            begin
                font_height_next = rx_byte;
                mode_next        = M_CMD;
            end
            M_POS_X:
            begin
                start_x_next = rx_byte;
                mode_next    = M_POS_Y;
            end
            M_POS_Y:
            begin
                start_y_next = rx_byte;
                mode_next    = M_CMD;
            end
            M_COLOUR:
            begin
                colour_next = rx_byte;
                mode_next   = M_CMD;
            end
            M_LINE_X:
            begin
                end_x_next = rx_byte;
                mode_next  = M_LINE_Y;
            end
            M_BOX_X:
            begin
                end_x_next = rx_byte;
                mode_next  = M_BOX_Y;
            end
            M_LINE_Y, M_BOX_Y:
            begin
                end_y_next  = rx_byte;
                res.command = (mode_reg == M_LINE_Y) ? DRAW_LINE : DRAW_BOX;
                res.x_start = start_x_reg;
                res.y_start = start_y_reg;
                res.x_end   = end_x_reg;
                res.y_end   = rx_byte;
                res.red     = channel_level(colour_reg[5:4]);
                res.green   = channel_level(colour_reg[3:2]);
                res.blue    = channel_level(colour_reg[1:0]);
                res_valid   = 1'b1;
                mode_next   = M_CMD;
            end
            M_CIRCLE:
            begin
                end_x_next  = rx_byte;
                res.command = DRAW_CIRCLE;
                res.x_start = start_x_reg;
                res.y_start = start_y_reg;
                res.x_end   = rx_byte;
                res.red     = channel_level(colour_reg[5:4]);
                res.green   = channel_level(colour_reg[3:2]);
                res.blue    = channel_level(colour_reg[1:0]);
                res_valid   = 1'b1;
                mode_next   = M_CMD;
            end
            M_FILL:
            begin
                // The argument is kept as the colour; the fill uses its own colour.
                colour_next = rx_byte;
                res.command = DRAW_FILL;
                res.red     = channel_level(cfg.fill_colour_code[5:4]);
                res.green   = channel_level(cfg.fill_colour_code[3:2]);
                res.blue    = channel_level(cfg.fill_colour_code[1:0]);
                res_valid   = 1'b1;
                mode_next   = M_CMD;
            end
            M_PIXEL_X:
            begin
                end_x_next = rx_byte;
                mode_next  = M_PIXEL_Y;
            end
            M_PIXEL_Y:
            begin
                end_y_next  = rx_byte;
                res.command = DRAW_PIXEL;
                res.x_start = start_x_reg;
                res.y_start = start_y_reg;
                res.red     = PIXEL_RED;
                res_valid   = 1'b1;
                mode_next   = M_CMD;
            end
            default: mode_next = M_START;
        endcase

        // Nothing happens without an accepted byte.
        if (!byte_valid)
            res_valid = 1'b0;
    end

    // State registers, updated on each accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= M_START;
            text_count_reg  <= 5'd0;
            font_width_reg  <= RST_DEFAULT_FONT_WIDTH;
            font_height_reg <= RST_DEFAULT_FONT_HEIGHT;
            start_x_reg     <= 8'd0;
            start_y_reg     <= 8'd0;
            end_x_reg       <= 8'd0;
            end_y_reg       <= 8'd0;
            colour_reg      <= RST_DEFAULT_COLOUR_CODE;
        end
        else if (byte_valid)
        begin
            mode_reg        <= mode_next;
            text_count_reg  <= text_count_next;
            font_width_reg  <= font_width_next;
            font_height_reg <= font_height_next;
            start_x_reg     <= start_x_next;
            start_y_reg     <= start_y_next;
            end_x_reg       <= end_x_next;
            end_y_reg       <= end_y_next;
            colour_reg      <= colour_next;
        end
    end

endmodule

@@ sv/dcbp_out_skid.sv @@
// Result register with a skid stage so that input and output stall independently.
`timescale 1ns / 1ps

module dcbp_out_skid (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  dcbp_pkg::dcbp_result_t in_data,
    output logic                   in_ready,
    output logic                   out_valid,
    output dcbp_pkg::dcbp_result_t out_data,
    input  logic                   out_ready
);
    import dcbp_pkg::*;

    logic         out_valid_reg;
    logic         skid_valid_reg;
    dcbp_result_t out_data_reg;
    dcbp_result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control: the skid stage fills only when the output register is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_valid)
                out_data_reg <= in_data;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the display command byte parser: directed script, then random frames.
`timescale 1ns / 1ps

module tb_top;

    import dcbp_pkg::*;

    localparam int NumScriptRows = 46;
    localparam int StallLimit    = 5000;
    localparam int PhaseBytes    = 55;

    // One byte of the directed script, with the draw command it must cause where one is typed in.
    typedef struct {
        logic [7:0]   rx;
        bit           typed;
        dcbp_result_t want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_data = '0;

    // Copy of the configuration registers.
    logic [4:0] text_len_limit  = RST_MAX_TEXT_LENGTH;
    logic [7:0] frame_colour    = RST_DEFAULT_COLOUR_CODE;
    logic [7:0] frame_font_w    = RST_DEFAULT_FONT_WIDTH;
    logic [7:0] frame_font_h    = RST_DEFAULT_FONT_HEIGHT;
    logic [7:0] fill_colour     = RST_FILL_COLOUR_CODE;

    // Parser state as the block should hold it.
    dcbp_mode_t mode       = M_START;
    logic [4:0] char_count = '0;
    logic [7:0] font_w     = RST_DEFAULT_FONT_WIDTH;
    logic [7:0] font_h     = RST_DEFAULT_FONT_HEIGHT;
    logic [7:0] pos_x      = '0;
    logic [7:0] pos_y      = '0;
    logic [7:0] tgt_x      = '0;
    logic [7:0] tgt_y      = '0;
    logic [7:0] colour     = RST_DEFAULT_COLOUR_CODE;

    dcbp_result_t pending_draws [$];
    row_t         sent_rows [$];
    row_t         script [NumScriptRows];

    int errors        = 0;
    int quiet_cycles  = 0;
    int bytes_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    display_command_byte_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock.
    always #10 clk = ~clk;

    // Font number from the width code and the height; the height counts as a signed byte.
    function automatic logic [4:0] font_for(input logic [7:0] wcode, input logic [7:0] hgt);
        int         h;
        logic [4:0] style;
        h = int'($signed(hgt));
        // Outline, bold and regular variants sit next to each other in the font list.
        style = wcode[7] ? 5'd1 : (wcode[6] ? 5'd0 : 5'd2);
        case (wcode[3:0])
            4'd5:    return (h < 8) ? 5'd1 : 5'd2;
            4'd6:
            begin
                if (h < 10)
                    return 5'd3;
                if (h < 11)
                    return 5'd4;
                if (h < 13)
                    return 5'd5;
                return 5'd6 + style;
            end
            4'd7:    return ((h < 14) ? 5'd9 : 5'd12) + style;
            4'd8:    return 5'd15 + style;
            4'd9:    return ((h < 17) ? 5'd18 : 5'd20) + (wcode[7] ? 5'd0 : 5'd1);
            4'd10:   return 5'd22;
            4'd11:   return 5'd23;
            4'd12:   return 5'd24;
            default: return 5'd0;
        endcase
    endfunction

    // Each channel is a 2-bit field of the colour code scaled by 85.
    function automatic void set_colour(inout dcbp_result_t d, input logic [7:0] code);
        d.red   = 8'(85 * code[5:4]);
        d.green = 8'(85 * code[3:2]);
        d.blue  = 8'(85 * code[1:0]);
    endfunction

    // Advances the parser copy by one byte and gives the draw command it causes, if any.
    function automatic void parse_byte(input logic [7:0] b, output bit emits,
                                       output dcbp_result_t d);
        logic [7:0] ch;
        emits = 1'b0;
        d     = '0;
        ch    = b;
        case (mode)
            M_START:
            begin
                // A frame start restores the drawing settings.
                if (b == BYTE_FRAME_START)
                begin
                    char_count = '0;
                    font_w     = frame_font_w;
                    font_h     = frame_font_h;
                    pos_x      = '0;
                    pos_y      = '0;
                    tgt_x      = '0;
                    tgt_y      = '0;
                    colour     = frame_colour;
                    mode       = M_CMD;
                end
            end
            M_CMD:
            begin
                if (b == BYTE_COMMAND)
                    mode = M_INSTR;
            end
            M_INSTR:
            begin
                mode = M_CMD;
                case (b)
                    BYTE_FRAME_END:
                    begin
                        mode      = M_START;
                        d.command = DRAW_FRAME_END;
                        emits     = 1'b1;
                    end
                    LETTER_CLEAR:
                    begin
                        d.command = DRAW_CLEAR;
                        emits     = 1'b1;
                    end
                    LETTER_REFRESH:
                    begin
                        d.command = DRAW_REFRESH;
                        emits     = 1'b1;
                    end
                    LETTER_TEXT:
                    begin
                        mode       = M_TEXT;
                        char_count = '0;
                    end
                    LETTER_FONT:     mode = M_FONT_W;
                    LETTER_LINE:     mode = M_LINE_X;
                    LETTER_POSITION: mode = M_POS_X;
                    LETTER_COLOUR:   mode = M_COLOUR;
                    LETTER_CIRCLE:   mode = M_CIRCLE;
                    LETTER_BOX:      mode = M_BOX_X;
                    LETTER_FILL:     mode = M_FILL;
                    LETTER_PIXEL:    mode = M_PIXEL_X;
                    default:         ;
                endcase
            end
            M_TEXT:
            begin
                // In the 5x8 font a zero is drawn as the letter O.
                if (b == CHAR_ZERO && font_w == 8'd5 && font_h == 8'd8)
                    ch = CHAR_O;
                char_count   = char_count + 5'd1;
                d.command    = DRAW_TEXT_CHAR;
                d.x_start    = pos_x;
                d.y_start    = pos_y;
                set_colour(d, colour);
                d.font_index = font_for(font_w, font_h);
                d.text_char  = ch;
                d.text_last  = (char_count >= text_len_limit) || (ch == 8'h00);
                emits        = 1'b1;
                if (d.text_last)
                    mode = M_CMD;
            end
            M_FONT_W:
            begin
                font_w = b;
                mode   = M_FONT_H;
            end
            M_FONT_H:
            begin
                font_h = b;
                mode   = M_CMD;
            end
            M_POS_X:
            begin
                pos_x = b;
                mode  = M_POS_Y;
            end
            M_POS_Y:
            begin
                pos_y = b;
                mode  = M_CMD;
            end
            M_COLOUR:
            begin
                colour = b;
                mode   = M_CMD;
            end
            M_LINE_X:
            begin
                tgt_x = b;
                mode  = M_LINE_Y;
            end
            M_BOX_X:
            begin
                tgt_x = b;
                mode  = M_BOX_Y;
            end
            M_LINE_Y, M_BOX_Y:
            begin
                tgt_y     = b;
                d.command = (mode == M_LINE_Y) ? DRAW_LINE : DRAW_BOX;
                d.x_start = pos_x;
                d.y_start = pos_y;
                d.x_end   = tgt_x;
                d.y_end   = tgt_y;
                set_colour(d, colour);
                emits     = 1'b1;
                mode      = M_CMD;
            end
            M_CIRCLE:
            begin
                tgt_x     = b;
                d.command = DRAW_CIRCLE;
                d.x_start = pos_x;
                d.y_start = pos_y;
                d.x_end   = tgt_x;
                set_colour(d, colour);
                emits     = 1'b1;
                mode      = M_CMD;
            end
            M_FILL:
            begin
                // The argument only replaces the colour code; the fill uses its own register.
                colour    = b;
                d.command = DRAW_FILL;
                set_colour(d, fill_colour);
                emits     = 1'b1;
                mode      = M_CMD;
            end
            M_PIXEL_X:
            begin
                tgt_x = b;
                mode  = M_PIXEL_Y;
            end
            M_PIXEL_Y:
            begin
                // The pixel lands at the start position, always in the same red.
                tgt_y     = b;
                d.command = DRAW_PIXEL;
                d.x_start = pos_x;
                d.y_start = pos_y;
                d.red     = PIXEL_RED;
                emits     = 1'b1;
                mode      = M_CMD;
            end
            default:      mode = M_START;
        endcase
    endfunction

    function automatic dcbp_result_t draw(input dcbp_cmd_t cmd, input logic [7:0] xs, ys,
                                          xe, ye, r, g, b);
        dcbp_result_t d;
        d         = '0;
        d.command = cmd;
        d.x_start = xs;
        d.y_start = ys;
        d.x_end   = xe;
        d.y_end   = ye;
        d.red     = r;
        d.green   = g;
        d.blue    = b;
        return d;
    endfunction

    function automatic row_t byte_row(input logic [7:0] b);
        row_t r;
        r.rx    = b;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic row_t draw_row(input logic [7:0] b, input dcbp_result_t d);
        row_t r;
        r.rx    = b;
        r.typed = 1'b1;
        r.want  = d;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want, got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Sends one byte after a random gap and waits until the request is taken.
    task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input dcbp_result_t want = '0);
        row_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        r.rx    = b;
        r.typed = typed;
        r.want  = want;
        sent_rows.push_back(r);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    // Holds the sender back until every draw command has come out, then lets the parser settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_draws.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input dcbp_cfg_index_t idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_MAX_TEXT_LENGTH:     text_len_limit = val[4:0];
            CFG_DEFAULT_COLOUR_CODE: frame_colour   = val;
            CFG_DEFAULT_FONT_WIDTH:  frame_font_w   = val;
            CFG_DEFAULT_FONT_HEIGHT: frame_font_h   = val;
            CFG_FILL_COLOUR_CODE:    fill_colour    = val;
            default:                 ;
        endcase
    endtask

    task automatic load_settings(input logic [4:0] lim, input logic [7:0] colr, fw, fh, fill);
        write_reg(CFG_MAX_TEXT_LENGTH, {3'b000, lim});
        write_reg(CFG_DEFAULT_COLOUR_CODE, colr);
        write_reg(CFG_DEFAULT_FONT_WIDTH, fw);
        write_reg(CFG_DEFAULT_FONT_HEIGHT, fh);
        write_reg(CFG_FILL_COLOUR_CODE, fill);
        cfg_we <= 1'b0;
    endtask

    // One frame of random commands, with stray bytes, unknown letters and cut-short commands.
    task automatic send_random_frame();
        int         n_chars;
        logic [7:0] ch;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
        push_byte(BYTE_FRAME_START);
        repeat ($urandom_range(1, 8))
        begin
            if ($urandom_range(15) == 0)
                push_byte(8'($urandom_range(255)));
            push_byte(BYTE_COMMAND);
            case ($urandom_range(12))
                0:  push_byte(LETTER_CLEAR);
                1:  push_byte(LETTER_REFRESH);
                2:
                begin
                    // Text ends on a zero byte or at the length limit.
                    push_byte(LETTER_TEXT);
                    n_chars = 0;
                    do
                    begin
                        case ($urandom_range(9))
                            0:       ch = 8'h00;
                            1, 2:    ch = CHAR_ZERO;
                            default: ch = 8'($urandom_range(1, 255));
                        endcase
                        push_byte(ch);
                        n_chars++;
                    end
                    while (ch != 8'h00 && n_chars < text_len_limit);
                end
                3:
                begin
                    push_byte(LETTER_FONT);
                    if ($urandom_range(3) == 0)
                    begin
                        push_byte(8'd5);
                        push_byte(8'd8);
                    end
                    else
                    begin
                        push_byte({2'($urandom_range(3)), 2'($urandom_range(3)),
                                   4'($urandom_range(5, 12))});
                        push_byte($urandom_range(1) ? 8'($urandom_range(20))
                                                    : 8'($urandom_range(255)));
                    end
                end
                4:
                begin
                    push_byte(LETTER_LINE);
                    push_byte(8'($urandom_range(255)));
                    push_byte(8'($urandom_range(255)));
                end
                5:
                begin
                    push_byte(LETTER_POSITION);
                    push_byte(8'($urandom_range(255)));
                    push_byte(8'($urandom_range(255)));
                end
                6:
                begin
                    push_byte(LETTER_COLOUR);
                    push_byte(8'($urandom_range(255)));
                end
                7:
                begin
                    push_byte(LETTER_CIRCLE);
                    push_byte(8'($urandom_range(255)));
                end
                8:
                begin
                    push_byte(LETTER_BOX);
                    push_byte(8'($urandom_range(255)));
                    push_byte(8'($urandom_range(255)));
                end
                9:
                begin
                    push_byte(LETTER_FILL);
                    push_byte(8'($urandom_range(255)));
                end
                10:
                begin
                    push_byte(LETTER_PIXEL);
                    push_byte(8'($urandom_range(255)));
                    push_byte(8'($urandom_range(255)));
                end
                11: push_byte(8'($urandom_range(255)));
                default:
                begin
                    // A box missing its last argument: the next command byte completes it.
                    push_byte(LETTER_BOX);
                    push_byte(8'($urandom_range(255)));
                end
            endcase
        end
        if ($urandom_range(9) != 0)
        begin
            push_byte(BYTE_COMMAND);
            push_byte(BYTE_FRAME_END);
        end
    endtask

    // Receiver stalls.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Result checking and prediction at every accepted request.
    always @(posedge clk)
    begin : monitor
        dcbp_result_t w;
        dcbp_result_t d;
        row_t         r;
        bit           emits;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_draws.size() == 0)
            begin
                errors++;
                $display("%0t: expected no draw command, got tuser %h tdata %h tlast %b",
                         $time, m_tuser, m_tdata, m_tlast);
            end
            else
            begin
                w = pending_draws.pop_front();
                compare_field("command", 8'(w.command), 8'(m_tuser));
                compare_field("x_start", w.x_start, m_tdata[7:0]);
                compare_field("y_start", w.y_start, m_tdata[15:8]);
                compare_field("x_end", w.x_end, m_tdata[23:16]);
                compare_field("y_end", w.y_end, m_tdata[31:24]);
                compare_field("red", w.red, m_tdata[39:32]);
                compare_field("green", w.green, m_tdata[47:40]);
                compare_field("blue", w.blue, m_tdata[55:48]);
                compare_field("font_index", 8'(w.font_index), 8'(m_tdata[60:56]));
                compare_field("text_char", w.text_char, m_tdata[68:61]);
                compare_field("text_last", 8'(w.text_last), 8'(m_tlast));
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            parse_byte(s_tdata, emits, d);
            r.typed = 1'b0;
            if (sent_rows.size() != 0)
                r = sent_rows.pop_front();
            if (emits)
                pending_draws.push_back(r.typed ? r.want : d);
        end
    end

    // Watchdog on cycles without any request taken.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == StallLimit)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus.
    initial
    begin
        script = '{
            // Stray byte before the frame, then the frame start.
            byte_row(8'h00),
            byte_row(BYTE_FRAME_START),
            byte_row(BYTE_COMMAND),
            draw_row(LETTER_CLEAR, draw(DRAW_CLEAR, 0, 0, 0, 0, 0, 0, 0)),
            byte_row(8'h41),
            byte_row(BYTE_COMMAND),
            draw_row(LETTER_REFRESH, draw(DRAW_REFRESH, 0, 0, 0, 0, 0, 0, 0)),
            // Fill draws in the fill colour and keeps its argument as the colour code.
            byte_row(BYTE_COMMAND),
            byte_row(LETTER_FILL),
            draw_row(8'hFF, draw(DRAW_FILL, 0, 0, 0, 0, 85, 85, 85)),
            byte_row(BYTE_COMMAND),
            byte_row(LETTER_POSITION),
            byte_row(8'h80),
            byte_row(8'h7F),
            byte_row(BYTE_COMMAND),
            byte_row(LETTER_LINE),
            byte_row(8'h7F),
            draw_row(8'h80, draw(DRAW_LINE, 8'h80, 8'h7F, 8'h7F, 8'h80, 255, 255, 255)),
            // Pixel arguments are stored but the pixel goes to the start position.
            byte_row(BYTE_COMMAND),
            byte_row(LETTER_PIXEL),
            byte_row(8'h00),
            draw_row(8'hFF, draw(DRAW_PIXEL, 8'h80, 8'h7F, 0, 0, PIXEL_RED, 0, 0)),
            byte_row(BYTE_COMMAND),
            byte_row(LETTER_COLOUR),
            byte_row(8'h39),
            byte_row(BYTE_COMMAND),
            byte_row(LETTER_CIRCLE),
            byte_row(8'hFF),
            byte_row(BYTE_COMMAND),
            byte_row(LETTER_BOX),
            byte_row(8'h00),
            byte_row(8'h01),
            // 5x8 font, then a text with a zero character and the terminator.
            byte_row(BYTE_COMMAND),
            byte_row(LETTER_FONT),
            byte_row(8'd5),
            byte_row(8'd8),
            byte_row(BYTE_COMMAND),
            byte_row(LETTER_TEXT),
            byte_row(CHAR_ZERO),
            byte_row(8'hFF),
            byte_row(8'h00),
            // Unknown letter, and a frame start byte inside the frame.
            byte_row(BYTE_COMMAND),
            byte_row(8'h51),
            byte_row(BYTE_FRAME_START),
            byte_row(BYTE_COMMAND),
            draw_row(BYTE_FRAME_END, draw(DRAW_FRAME_END, 0, 0, 0, 0, 0, 0, 0))
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 6; p++)
        begin
            send_idle_pct = (p < 2) ? 17 : ((p < 4) ? 88 : 0);
            recv_idle_pct = (p < 2) ? 88 : ((p < 4) ? 17 : 0);
            if (p == 0)
            begin
                for (int i = 0; i < NumScriptRows; i++)
                    push_byte(script[i].rx, script[i].typed, script[i].want);
            end
            else
            begin
                wait_drained();
                case (p)
                    1:       load_settings(5'd31, 8'hFF, 8'd5, 8'd8, 8'h00);
                    2:       load_settings(5'd1, 8'h00, 8'hC7, 8'h80, 8'hFF);
                    3:       load_settings(5'd0, 8'h2A, 8'h46, 8'h0E, 8'h3F);
                    default: load_settings(5'($urandom_range(1, 31)), 8'($urandom_range(255)),
                                           8'($urandom_range(255)), 8'($urandom_range(255)),
                                           8'($urandom_range(255)));
                endcase
            end
            bytes_sent = 0;
            while (bytes_sent < PhaseBytes)
            begin
                send_random_frame();
                if ($urandom_range(9) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
